@@ hw/rtl/u8sv_pkg.sv @@
// Shared types, codes and helpers of the UTF-8 stream validator.
`timescale 1ns / 1ps

package u8sv_pkg;

   localparam int unsigned CpWidth = 21;

   typedef logic [CpWidth-1:0] cp_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_OUTSIDE   = 3'd1,
      ST_TRUNCATED = 3'd2,
      ST_OVERLONG  = 3'd3,
      ST_BAD_TRAIL = 3'd4,
      ST_INVALID   = 3'd5
   } status_type;

   localparam cp_type CpMaxValid    = 21'h0EFFFD;
   localparam cp_type CpSurrLow     = 21'h00D800;
   localparam cp_type CpSurrHigh    = 21'h00DFFF;
   localparam cp_type CpNonCharLow  = 21'h00FDD0;
   localparam cp_type CpNonCharHigh = 21'h00FDEF;
   localparam cp_type CpPrivLow     = 21'h00E000;
   localparam cp_type CpPrivHigh    = 21'h00F8FF;
   localparam logic [15:0] CpPlaneEndMask = 16'hFFFE;
   localparam logic [7:0] LeadOverlongMask = 8'hFE;
   localparam logic [7:0] LeadTwoMin       = 8'hC0;
   localparam logic [7:0] TrailTag         = 8'h80;
   localparam logic [7:0] TrailBitsMask    = 8'h3F;
   localparam logic [7:0] LeadThreeOvl     = 8'hE0;
   localparam logic [7:0] LeadFourOvl      = 8'hF0;

   // Staged input byte between the input register and the step logic.
   typedef struct packed {
      logic       valid;
      logic [7:0] byte_value;
      logic       string_last;
   } in_stage_type;

   // One step's result towards the result register.
   typedef struct packed {
      logic       emit;
      cp_type     code_point;
      status_type status;
      logic       at_string_end;
   } step_result_type;

   function automatic logic point_ok(input cp_type c);
      logic bad;
      bad = (c > CpMaxValid)
         || (c >= CpSurrLow && c <= CpSurrHigh)
         || ((c[15:0] & CpPlaneEndMask) == CpPlaneEndMask)
         || (c >= CpNonCharLow && c <= CpNonCharHigh)
         || (c >= CpPrivLow && c <= CpPrivHigh);
      return !bad;
   endfunction

endpackage

@@ hw/rtl/u8sv_if.sv @@
// Handshake channel interfaces for the byte input and the result output.
`timescale 1ns / 1ps

interface u8sv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       string_last;

   modport source (output valid, output byte_value, output string_last, input ready);
   modport sink   (input valid, input byte_value, input string_last, output ready);
endinterface

interface u8sv_rsp_if;
   logic                  valid;
   logic                  ready;
   u8sv_pkg::cp_type      code_point;
   u8sv_pkg::status_type  status;
   logic                  at_string_end;

   modport source (output valid, output code_point, output status, output at_string_end,
                   input ready);
   modport sink   (input valid, input code_point, input status, input at_string_end,
                   output ready);
endinterface

@@ hw/rtl/u8sv_in_reg.sv @@
// Input register: captures one byte transfer and holds it until the step logic takes it.
`timescale 1ns / 1ps

module u8sv_in_reg (
   input  logic                    clock,
   input  logic                    reset,
   u8sv_req_if.sink                req_chan,
   input  logic                    take,
   output u8sv_pkg::in_stage_type  stage
);
   import u8sv_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       load;

   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_chan.byte_value;
         last_ff <= req_chan.string_last;
      end
   end

   assign stage = '{valid: valid_ff, byte_value: byte_ff, string_last: last_ff};

endmodule

@@ hw/rtl/u8sv_step.sv @@
// Sequence state and the per-byte decode and check logic.
`timescale 1ns / 1ps

module u8sv_step (
   input  logic                       clock,
   input  logic                       reset,
   input  u8sv_pkg::in_stage_type     stage,
   input  logic                       advance,
   output u8sv_pkg::step_result_type  result
);
   import u8sv_pkg::*;

   cp_type     acc_ff, acc_in;
   logic [7:0] lead_ff, lead_in;
   logic [2:0] exp_ff, exp_in;
   logic [2:0] seen_ff, seen_in;
   status_type pend_ff, pend_in;
   logic       skip_ff, skip_in;

   logic [7:0] b;
   logic       last;
   status_type pe;
   status_type st;
   cp_type     acc_next;
   logic [2:0] seen_next;

   assign b    = stage.byte_value;
   assign last = stage.string_last;

   always_comb begin
      acc_in  = acc_ff;
      lead_in = lead_ff;
      exp_in  = exp_ff;
      seen_in = seen_ff;
      pend_in = pend_ff;
      skip_in = skip_ff;
      result  = '{emit: 1'b0, code_point: '0, status: ST_OK, at_string_end: last};
      pe        = pend_ff;
      st        = ST_OK;
      acc_next  = {acc_ff[CpWidth-7:0], b[5:0]};
      seen_next = seen_ff + 3'd1;

      if (skip_ff) begin
         if (last) begin
            skip_in = 1'b0;
            acc_in  = '0;
            lead_in = '0;
            exp_in  = '0;
            seen_in = '0;
            pend_in = ST_OK;
         end
      end else if (exp_ff == 3'd0) begin
         priority if (!b[7]) begin
            result.emit       = 1'b1;
            result.code_point = cp_type'(b);
         end else if (!b[6] || b[7:3] == 5'b11111) begin
            // stray trailer or a lead of five bytes or more
            skip_in           = !last;
            result.emit       = 1'b1;
            result.code_point = cp_type'(b);
            result.status     = ST_OUTSIDE;
         end else if (last) begin
            result.emit       = 1'b1;
            result.code_point = cp_type'(b);
            result.status     = ST_TRUNCATED;
         end else begin
            lead_in = b;
            seen_in = 3'd1;
            pend_in = ST_OK;
            priority if (!b[5]) begin
               exp_in = 3'd2;
               acc_in = cp_type'(b[4:0]);
            end else if (!b[4]) begin
               exp_in = 3'd3;
               acc_in = cp_type'(b[3:0]);
            end else begin
               exp_in = 3'd4;
               acc_in = cp_type'(b[2:0]);
            end
         end
      end else begin
         if (seen_ff == 3'd1 &&
             ((lead_ff & LeadOverlongMask) == LeadTwoMin
              || (lead_ff == LeadThreeOvl && b[7:5] == 3'b100)
              || (lead_ff == LeadFourOvl && b[7:4] == 4'b1000))) begin
            pe = ST_OVERLONG;
         end
         if (pe == ST_OK && b[7:6] != 2'b10) begin
            pe = ST_BAD_TRAIL;
         end
         if (seen_next >= exp_ff) begin
            st = pe;
            if (st == ST_OK && !point_ok(acc_next)) begin
               st = ST_INVALID;
            end
            result.emit       = 1'b1;
            result.status     = st;
            result.code_point = (st == ST_OK) ? acc_next : cp_type'(lead_ff);
            acc_in  = '0;
            lead_in = '0;
            exp_in  = '0;
            seen_in = '0;
            pend_in = ST_OK;
            skip_in = (st != ST_OK) && !last;
         end else if (last) begin
            // string ended mid-sequence: drop any pending error
            result.emit       = 1'b1;
            result.status     = ST_TRUNCATED;
            result.code_point = cp_type'(lead_ff);
            acc_in  = '0;
            lead_in = '0;
            exp_in  = '0;
            seen_in = '0;
            pend_in = ST_OK;
         end else begin
            acc_in  = acc_next;
            seen_in = seen_next;
            pend_in = pe;
         end
      end
      result.emit = result.emit && stage.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         lead_ff <= '0;
         exp_ff  <= '0;
         seen_ff <= '0;
         pend_ff <= ST_OK;
         skip_ff <= 1'b0;
      end else if (advance) begin
         acc_ff  <= acc_in;
         lead_ff <= lead_in;
         exp_ff  <= exp_in;
         seen_ff <= seen_in;
         pend_ff <= pend_in;
         skip_ff <= skip_in;
      end
   end

   a_seen_below_len: assert property (@(posedge clock) disable iff (reset)
      exp_ff != 3'd0 |-> (seen_ff >= 3'd1 && seen_ff < exp_ff))
      else $error("byte count of open sequence out of range");

   a_skip_idle: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> (exp_ff == 3'd0 && pend_ff == ST_OK))
      else $error("skipping while a sequence is open");

   a_no_single_len: assert property (@(posedge clock) disable iff (reset)
      exp_ff != 3'd1)
      else $error("open sequence of length one");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && stage.string_last) |=> (exp_ff == 3'd0 && !skip_ff))
      else $error("state not cleared at string end");

endmodule

@@ hw/rtl/u8sv_rsp_reg.sv @@
// Result register: holds one result until the sink takes the transfer.
`timescale 1ns / 1ps

module u8sv_rsp_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  u8sv_pkg::step_result_type  result,
   input  logic                       advance,
   output logic                       free,
   u8sv_rsp_if.source                 rsp_chan
);
   import u8sv_pkg::*;

   logic       valid_ff, valid_in;
   cp_type     cp_ff;
   status_type st_ff;
   logic       end_ff;
   logic       load;

   assign free = !valid_ff || rsp_chan.ready;
   assign load = advance && result.emit;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cp_ff  <= result.code_point;
         st_ff  <= result.status;
         end_ff <= result.at_string_end;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.code_point    = cp_ff;
   assign rsp_chan.status        = st_ff;
   assign rsp_chan.at_string_end = end_ff;

endmodule

@@ hw/rtl/utf8_stream_validator_unit.sv @@
// Top level of the UTF-8 stream validator: input register, step logic, result register.
// Path: a byte goes from the input register through the step logic into the result register.
// Throughput: one byte per cycle when the result register is free, set by the step state update.
// A full result register stalls the input only while the sink holds off rsp ready.
// Reset (synchronous, active high) clears both valid flags and all sequence state.
`timescale 1ns / 1ps

module utf8_stream_validator_unit (
   input  logic        clock,
   input  logic        reset,
   u8sv_req_if.sink    req_chan,
   u8sv_rsp_if.source  rsp_chan
);
   import u8sv_pkg::*;

   in_stage_type    stage;
   step_result_type result;
   logic            out_free;
   logic            advance;

   // Advance the staged byte once the result register can take whatever it yields.
   // A byte that yields nothing still waits for a free slot; this keeps the
   // control simple, but holds such a byte while the sink holds off rsp ready.
   assign advance = stage.valid && out_free;

   // Capture the byte transfer; hold it until the step logic consumes it.
   u8sv_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (advance),
      .stage    (stage)
   );

   // Decode one byte against the open sequence and update the state.
   u8sv_step u_step (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .advance (advance),
      .result  (result)
   );

   // Drop the result into the output register; it leaves on the rsp transfer.
   u8sv_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .advance  (advance),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

   a_adv_free: assert property (@(posedge clock) disable iff (reset)
      advance |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("step advanced into an occupied result register");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      (advance && result.emit) |=> rsp_chan.valid)
      else $error("emitted result missing from output");

   a_ok_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == ST_OK) |-> point_ok(rsp_chan.code_point))
      else $error("invalid code point reported as good");

endmodule

@@ test/utf8_decode_checker.sv @@
// Checker that predicts the decoded result of every byte transfer and compares it.
`timescale 1ns / 1ps

module utf8_decode_checker
   import u8sv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   u8sv_req_if         req_mon,
   u8sv_rsp_if         rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned results_pending
);

   typedef struct packed {
      cp_type     code_point;
      status_type status;
      logic       at_string_end;
   } decoded_type;

   decoded_type expected_q[$];
   decoded_type oldest;

   // decoder state as the block should hold it
   cp_type      acc_cp         = '0;
   logic [7:0]  open_lead      = '0;
   logic [2:0]  seq_len        = '0;
   logic [2:0]  seq_taken      = '0;
   status_type  held_error     = ST_OK;
   logic        drop_until_end = 1'b0;
   int unsigned fail_total     = 0;
   int unsigned pending_total  = 0;

   assign mismatch_count  = fail_total;
   assign results_pending = pending_total;

   task automatic report_mismatch(input string what);
      fail_total++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   task automatic clear_sequence();
      acc_cp     = '0;
      open_lead  = '0;
      seq_len    = '0;
      seq_taken  = '0;
      held_error = ST_OK;
   endtask

   task automatic expect_result(input cp_type cp, input status_type st, input logic at_end);
      expected_q.push_back('{code_point: cp, status: st, at_string_end: at_end});
   endtask

   // Advance the predicted decoder by one byte transfer.
   task automatic decode_byte(input logic [7:0] b, input logic last);
      logic [2:0] lead_len;
      status_type verdict;
      cp_type     out_cp;
      logic       allowed;
      if (drop_until_end) begin
         if (last) begin
            drop_until_end = 1'b0;
            clear_sequence();
         end
      end else if (seq_len == 3'd0) begin
         if (b < 8'h80) begin
            expect_result(cp_type'(b), ST_OK, last);
         end else begin
            if (b < 8'hC0 || b >= 8'hF8) lead_len = 3'd0;
            else if (b < 8'hE0) lead_len = 3'd2;
            else if (b < 8'hF0) lead_len = 3'd3;
            else lead_len = 3'd4;
            if (lead_len == 3'd0) begin
               drop_until_end = !last;
               expect_result(cp_type'(b), ST_OUTSIDE, last);
            end else if (last) begin
               expect_result(cp_type'(b), ST_TRUNCATED, 1'b1);
            end else begin
               open_lead  = b;
               seq_len    = lead_len;
               seq_taken  = 3'd1;
               held_error = ST_OK;
               acc_cp     = cp_type'(b & (8'hFF >> (lead_len + 3'd1)));
            end
         end
      end else begin
         // overlong is judged on the second byte only
         if (seq_taken == 3'd1 && ((open_lead & 8'hFE) == 8'hC0
               || (open_lead == 8'hE0 && b[7:5] == 3'b100)
               || (open_lead == 8'hF0 && b[7:4] == 4'b1000)))
            held_error = ST_OVERLONG;
         if (held_error == ST_OK && b[7:6] != 2'b10) held_error = ST_BAD_TRAIL;
         acc_cp    = {acc_cp[CpWidth-7:0], b[5:0]};
         seq_taken = seq_taken + 3'd1;
         if (seq_taken >= seq_len) begin
            allowed = (acc_cp <= CpMaxValid)
               && !(acc_cp >= CpSurrLow && acc_cp <= CpSurrHigh)
               && !(&acc_cp[15:1])
               && !(acc_cp >= CpNonCharLow && acc_cp <= CpNonCharHigh)
               && !(acc_cp >= CpPrivLow && acc_cp <= CpPrivHigh);
            verdict = held_error;
            if (verdict == ST_OK && !allowed) verdict = ST_INVALID;
            out_cp = (verdict == ST_OK) ? acc_cp : cp_type'(open_lead);
            clear_sequence();
            if (verdict != ST_OK && !last) drop_until_end = 1'b1;
            expect_result(out_cp, verdict, last);
         end else if (last) begin
            out_cp = cp_type'(open_lead);
            clear_sequence();
            expect_result(out_cp, ST_TRUNCATED, 1'b1);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_sequence();
         drop_until_end = 1'b0;
         expected_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("result cp=%0h status=%0d with nothing expected",
                                         rsp_mon.code_point, rsp_mon.status));
            end else begin
               oldest = expected_q.pop_front();
               if (rsp_mon.code_point !== oldest.code_point)
                  report_mismatch($sformatf("code_point %0h, expected %0h",
                                            rsp_mon.code_point, oldest.code_point));
               if (rsp_mon.status !== oldest.status)
                  report_mismatch($sformatf("status %0d, expected %0d (cp %0h)",
                                            rsp_mon.status, oldest.status, oldest.code_point));
               if (rsp_mon.at_string_end !== oldest.at_string_end)
                  report_mismatch($sformatf("at_string_end %0b, expected %0b (cp %0h)",
                                            rsp_mon.at_string_end, oldest.at_string_end,
                                            oldest.code_point));
            end
         end
         if (req_mon.valid && req_mon.ready) decode_byte(req_mon.byte_value, req_mon.string_last);
      end
      pending_total <= expected_q.size();
   end

endmodule

@@ test/tb_top.sv @@
// Testbench top: clock, reset, byte stimulus, result back-pressure and the verdict.
`timescale 1ns / 1ps

module tb_top;
   import u8sv_pkg::*;

   localparam int unsigned RandomItemsPerPhase = 180;
   localparam int unsigned DrainCycles         = 8;

   // Directed strings; bit 8 marks the final byte of a string.
   localparam logic [8:0] DirectedStream [25] = '{
      9'h000, 9'h17F,                  // lowest and highest single byte
      9'h0C2, 9'h080,                  // smallest two-byte point
      9'h0F0, 9'h090, 9'h080, 9'h080,  // smallest four-byte point
      9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,  // above the highest valid point, closes the string
      9'h0E0, 9'h080, 9'h080, 9'h1FF,  // overlong, then a dropped final byte
      9'h0ED, 9'h0A0, 9'h180,          // surrogate
      9'h0C2, 9'h141,                  // trailer that is not 10xxxxxx
      9'h180,                          // stray continuation byte
      9'h1C2,                          // lead byte that ends the string
      9'h0E2, 9'h182                   // string ends inside a sequence
   };

   // Points on the borders of the invalid ranges and of each length.
   localparam cp_type SpecialPoints [23] = '{
      21'h000000, 21'h00007F, 21'h000080, 21'h0007FF, 21'h000800, 21'h00D7FF,
      21'h00D800, 21'h00DFFF, 21'h00E000, 21'h00F8FF, 21'h00F900, 21'h00FDCF,
      21'h00FDD0, 21'h00FDEF, 21'h00FFFD, 21'h00FFFE, 21'h00FFFF, 21'h010000,
      21'h01FFFF, 21'h0EFFFD, 21'h0EFFFE, 21'h10FFFF, 21'h1FFFFF
   };

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        byte_valid  = 1'b0;
   logic [7:0]  byte_data   = 8'h00;
   logic        byte_last   = 1'b0;
   logic        take_result = 1'b0;
   int unsigned idle_pct    = 0;
   int unsigned stall_pct   = 0;
   int unsigned counted_items;
   int unsigned mismatch_count;
   int unsigned results_pending;
   logic [7:0]  string_bytes[$];

   u8sv_req_if req_chan ();
   u8sv_rsp_if rsp_chan ();

   assign req_chan.valid       = byte_valid;
   assign req_chan.byte_value  = byte_data;
   assign req_chan.string_last = byte_last;
   assign rsp_chan.ready       = take_result;

   utf8_stream_validator_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   utf8_decode_checker decode_watch (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Hard stop in case a transfer never completes.
   initial begin
      #1_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Result side: hold off ready at random, one decision per edge.
   always @(posedge clock) begin
      take_result <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // Offer one byte, with random idle cycles first, and hold it until the transfer.
   // Valid stays high on return so back-to-back bytes need no second assignment.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         byte_valid <= 1'b0;
         @(posedge clock);
      end
      byte_valid <= 1'b1;
      byte_data  <= b;
      byte_last  <= last;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_string();
      for (int i = 0; i < string_bytes.size(); i++)
         send_byte(string_bytes[i], i == string_bytes.size() - 1);
   endtask

   // Drop valid and wait until every predicted result has come out.
   task automatic drain_results();
      byte_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   function automatic int unsigned shortest_form(input cp_type point);
      if (point < 21'h80) return 1;
      if (point < 21'h800) return 2;
      if (point < 21'h10000) return 3;
      return 4;
   endfunction

   // Append the point in a form of len bytes; longer than needed gives an overlong form.
   task automatic append_encoded(input cp_type point, input int unsigned len);
      logic [7:0] seq_bytes [4];
      cp_type     rest;
      rest = point;
      for (int i = int'(len) - 1; i >= 1; i--) begin
         seq_bytes[i] = {2'b10, rest[5:0]};
         rest = rest >> 6;
      end
      case (len)
         1: begin
            seq_bytes[0] = rest[7:0];
         end
         2: begin
            seq_bytes[0] = 8'hC0 | rest[7:0];
         end
         3: begin
            seq_bytes[0] = 8'hE0 | rest[7:0];
         end
         default: begin
            seq_bytes[0] = 8'hF0 | rest[7:0];
         end
      endcase
      for (int i = 0; i < int'(len); i++) string_bytes.push_back(seq_bytes[i]);
   endtask

   // Build one string: mostly well-formed sequences with random content, now and then
   // a broken one. Bytes after a broken sequence are ignored by the block, so they
   // do not add to the item count.
   task automatic build_random_string();
      cp_type      point;
      int unsigned len;
      int unsigned kind;
      int unsigned seq_count;
      int unsigned start;
      logic [7:0]  junk;
      logic        broken;
      string_bytes.delete();
      broken    = 1'b0;
      seq_count = $urandom_range(6, 1);
      for (int s = 0; s < int'(seq_count); s++) begin
         case ($urandom_range(3))
            0: begin
               point = SpecialPoints[$urandom_range(22)];
            end
            1: begin
               point = cp_type'($urandom_range(8'h7F));
            end
            2: begin
               point = cp_type'($urandom_range(16'hFFFF));
            end
            default: begin
               point = cp_type'($urandom_range(21'h1FFFFF));
            end
         endcase
         len   = shortest_form(point);
         start = string_bytes.size();
         kind  = $urandom_range(99);
         if (kind < 68) begin
            append_encoded(point, len);
         end else if (kind < 76) begin
            // overlong: a longer form than the point needs
            point = point & 21'h00FFFF;
            append_encoded(point, $urandom_range(4, shortest_form(point) + 1));
         end else if (kind < 84) begin
            // spoil one trailer
            if (len == 1) len = 2;
            append_encoded(point, len);
            junk = 8'($urandom_range(255));
            if ($urandom_range(1)) junk[7] = 1'b0;
            else junk[6] = 1'b1;
            string_bytes[start + $urandom_range(len - 1, 1)] = junk;
         end else if (kind < 90) begin
            // stray continuation byte or a lead of five bytes or more
            if ($urandom_range(1)) junk = 8'($urandom_range(8'hBF, 8'h80));
            else junk = 8'($urandom_range(8'hFF, 8'hF8));
            string_bytes.push_back(junk);
         end else if (kind < 95) begin
            // cut the sequence short and end the string there
            if (len == 1) len = 2;
            append_encoded(point, len);
            repeat ($urandom_range(len - 1, 1)) void'(string_bytes.pop_back());
            seq_count = 0;
         end else begin
            string_bytes.push_back(8'($urandom_range(255)));
         end
         if (!broken) counted_items += string_bytes.size() - start;
         if (kind >= 68 && kind < 95) begin
            broken = 1'b1;
            if ($urandom_range(9) < 7) seq_count = 0;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed strings, no idling.
      for (int i = 0; i < $size(DirectedStream); i++)
         send_byte(DirectedStream[i][7:0], DirectedStream[i][8]);
      drain_results();

      // Random strings over four phases of idling and result stalls; drain between phases so the block
      // sees the sender pause with nothing in flight.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 66;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 66;
            end
            default: begin
               idle_pct  = 17;
               stall_pct = 17;
            end
         endcase
         counted_items = 0;
         while (counted_items < RandomItemsPerPhase) begin
            build_random_string();
            send_string();
         end
         drain_results();
      end

      // Allow for the pipeline to settle before the verdict.
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
